// ===== hw/rtl/mccd_pkg.sv =====
// Shared types and constants for the motor current crush detector.
// Holds the transaction structs, register indexes and divider status.
// No dependencies.
package mccd_pkg;

  localparam int SAMPLE_BITS  = 10;
  localparam int LIMIT_W      = 10;
  localparam int AVG_W        = 10;
  localparam int INTERVAL_W   = 8;
  localparam int COUNT_W      = 8;
  localparam int BLANK_W      = 16;
  localparam int SUM_W        = SAMPLE_BITS + COUNT_W;
  localparam int STEP_W       = $clog2(SUM_W + 1);
  localparam int CFG_INDEX_W  = 8;
  localparam int CFG_DATA_W   = 16;

  localparam logic [AVG_W-1:0]      AVG_MAX         = {AVG_W{1'b1}};
  localparam logic [BLANK_W-1:0]    BLANK_MAX       = {BLANK_W{1'b1}};
  localparam logic [LIMIT_W-1:0]    LIMIT_RESET     = LIMIT_W'(100);
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET  = INTERVAL_W'(7);
  localparam logic [COUNT_W-1:0]    COUNT_RESET     = COUNT_W'(35);
  localparam logic [BLANK_W-1:0]    BLANK_RESET     = BLANK_W'(2000);

  localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_LIMIT   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_INTERVAL = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT    = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_BLANK_TIME      = CFG_INDEX_W'(3);

  typedef struct packed {
    logic                   run_active;
    logic [SAMPLE_BITS-1:0] current_sample;
  } mccd_in_t;

  typedef struct packed {
    logic             crush_detected;
    logic [AVG_W-1:0] average_current;
    logic             average_updated;
  } mccd_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mccd_div_stat_t;

endpackage

// ===== hw/rtl/mccd_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Divides the sample sum by the sample count; depends on mccd_pkg.
module mccd_div import mccd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SUM_W-1:0]   dividend,
  input  logic [COUNT_W-1:0] divisor,
  output mccd_div_stat_t     stat,
  output logic [SUM_W-1:0]   quotient
);

  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] dvs;
  logic [STEP_W-1:0]  steps;
  logic               busy;
  logic               done;
  logic [COUNT_W:0]   shifted;
  logic               fits;
  logic [COUNT_W:0]   diff;

  assign shifted = {rem, quotient[SUM_W-1]};
  assign fits    = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(SUM_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
      quotient <= {quotient[SUM_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== hw/rtl/motor_current_crush_detector_top.sv =====
// Motor current crush detector: tick sequencer, averaging and blanking state.
// Instantiates mccd_div for the block average; depends on mccd_pkg.
//
// Usage: one input transaction per millisecond tick on in_valid/in_ready
// carries run_active and current_sample; each gives exactly one output
// transaction on out_valid/out_ready with crush_detected, average_current
// and average_updated. Registers are written on cfg_valid/cfg_ready
// (cfg_ready is always high): index 0 current_limit, 1 sample_interval,
// 2 sample_count, 3 blank_time; other indexes are ignored.
// Flow: a tick that closes no block average goes from S_IDLE to S_DONE and
// then to the output register; one that closes an average first runs the
// serial divider in S_DIV, one quotient bit per cycle over SUM_W (18) bits.
// One tick is in work at a time: in_ready is high only while the sequencer
// is idle, so a new tick is not taken until the last one leaves S_DONE.
// The result sits in an output register; a stalled receiver holds it and
// the next tick waits in its final state until the register frees.
// Reset (rst, synchronous) clears the sequencer and accumulator state and out_valid and loads register defaults.
module motor_current_crush_detector_top import mccd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  mccd_in_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output mccd_out_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;

  logic [LIMIT_W-1:0]    current_limit;
  logic [INTERVAL_W-1:0] sample_interval;
  logic [COUNT_W-1:0]    sample_count;
  logic [BLANK_W-1:0]    blank_time;

  logic [INTERVAL_W-1:0] interval_ticks;
  logic [SUM_W-1:0]      sample_sum;
  logic [COUNT_W-1:0]    samples_taken;
  logic [AVG_W-1:0]      reported_average;
  logic [AVG_W-1:0]      compared_average;
  logic [BLANK_W-1:0]    blank_ticks;
  logic                  armed;
  logic                  avg_pend;
  logic                  run_held;

  logic                  accept;
  logic                  slot_free;
  logic                  finish;
  logic [INTERVAL_W:0]   tick_next;
  logic                  sample_hit;
  logic [SUM_W-1:0]      sum_acc;
  logic [COUNT_W-1:0]    taken_acc;
  logic [COUNT_W-1:0]    count_eff;
  logic                  avg_due;

  mccd_div_stat_t        div_stat;
  logic [SUM_W-1:0]      quotient;
  logic [AVG_W-1:0]      avg_sat;
  logic [AVG_W-1:0]      compared_next;
  logic [BLANK_W-1:0]    blank_next;
  logic                  armed_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign finish    = (state == S_DONE) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_limit   <= LIMIT_RESET;
      sample_interval <= INTERVAL_RESET;
      sample_count    <= COUNT_RESET;
      blank_time      <= BLANK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CURRENT_LIMIT:   current_limit   <= cfg_data[LIMIT_W-1:0];
        REG_SAMPLE_INTERVAL: sample_interval <= cfg_data[INTERVAL_W-1:0];
        REG_SAMPLE_COUNT:    sample_count    <= cfg_data[COUNT_W-1:0];
        REG_BLANK_TIME:      blank_time      <= cfg_data[BLANK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tick_next  = {1'b0, interval_ticks} + (INTERVAL_W+1)'(1);
    sample_hit = tick_next >= {1'b0, sample_interval};
    sum_acc    = sample_hit ? sample_sum + SUM_W'(in_data.current_sample) : sample_sum;
    taken_acc  = sample_hit ? samples_taken + COUNT_W'(1) : samples_taken;
    count_eff  = (sample_count == '0) ? COUNT_W'(1) : sample_count;
    avg_due    = (taken_acc >= count_eff) && (taken_acc != '0);
  end

  mccd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && avg_due),
    .dividend (sum_acc),
    .divisor  (taken_acc),
    .stat     (div_stat),
    .quotient (quotient)
  );

  always_comb begin
    avg_sat = (quotient > SUM_W'(AVG_MAX)) ? AVG_MAX : quotient[AVG_W-1:0];
    if (!run_held) begin
      compared_next = '0;
    end else if (avg_pend) begin
      compared_next = avg_sat;
    end else begin
      compared_next = compared_average;
    end
    blank_next = blank_ticks;
    armed_next = armed;
    if (run_held) begin
      if (!armed) begin
        if (blank_ticks != BLANK_MAX) begin
          blank_next = blank_ticks + BLANK_W'(1);
        end
        armed_next = blank_next >= blank_time;
      end
    end else begin
      blank_next = '0;
      armed_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      interval_ticks   <= '0;
      sample_sum       <= '0;
      samples_taken    <= '0;
      reported_average <= '0;
      compared_average <= '0;
      blank_ticks      <= '0;
      armed            <= 1'b0;
      avg_pend         <= 1'b0;
      run_held         <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            interval_ticks <= sample_hit ? '0 : tick_next[INTERVAL_W-1:0];
            sample_sum     <= sum_acc;
            samples_taken  <= taken_acc;
            avg_pend       <= avg_due;
            run_held       <= in_data.run_active;
            state          <= avg_due ? S_DIV : S_DONE;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            if (avg_pend) begin
              reported_average <= avg_sat;
              sample_sum       <= '0;
              samples_taken    <= '0;
            end
            compared_average <= compared_next;
            blank_ticks      <= blank_next;
            armed            <= armed_next;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data.crush_detected  <= armed_next && (compared_next > current_limit);
      out_data.average_current <= avg_pend ? avg_sat : reported_average;
      out_data.average_updated <= avg_pend;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_stat.busy)
    else $error("divider busy while sequencer idle");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV))
    else $error("divider finished outside divide state");

  a_avg_clears: assert property (@(posedge clk) disable iff (rst)
    (finish && avg_pend) |=> (sample_sum == '0 && samples_taken == '0))
    else $error("accumulator not cleared after average");

  a_crush_armed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.crush_detected) |-> armed)
    else $error("crush reported while not armed");
`endif

endmodule

// ===== tb/mccd_tick_checker.sv =====
// Tick checker for the motor current crush detector: predicts each tick's result
// from the accepted input and register writes, and compares the output transactions.
// Depends on mccd_pkg.
module mccd_tick_checker import mccd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  mccd_in_t               in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  mccd_out_t              out_data,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     results_due
);

  logic [LIMIT_W-1:0]    limit_reg;
  logic [INTERVAL_W-1:0] interval_reg;
  logic [COUNT_W-1:0]    count_reg;
  logic [BLANK_W-1:0]    blank_reg;

  logic [INTERVAL_W-1:0] interval_ticks;
  logic [SUM_W-1:0]      sample_sum;
  logic [COUNT_W-1:0]    samples_taken;
  logic [AVG_W-1:0]      reported_avg;
  logic [AVG_W-1:0]      compared_avg;
  logic [BLANK_W-1:0]    blank_ticks;
  logic                  armed;

  mccd_out_t tick_results[$];

  initial begin
    mismatches  = 0;
    results_due = 0;
  end

  function automatic mccd_out_t predict_tick(mccd_in_t tick);
    mccd_out_t        res;
    logic [COUNT_W-1:0] count_eff;
    logic [SUM_W-1:0]   avg;
    res       = '0;
    count_eff = (count_reg == '0) ? COUNT_W'(1) : count_reg;
    if (9'(interval_ticks) + 9'd1 >= 9'(interval_reg)) begin
      interval_ticks = '0;
      sample_sum     = sample_sum + SUM_W'(tick.current_sample);
      samples_taken  = samples_taken + COUNT_W'(1);
    end else begin
      interval_ticks = interval_ticks + INTERVAL_W'(1);
    end
    if (samples_taken >= count_eff && samples_taken != '0) begin
      avg = sample_sum / SUM_W'(samples_taken);
      if (avg > SUM_W'(AVG_MAX)) begin
        avg = SUM_W'(AVG_MAX);
      end
      reported_avg        = avg[AVG_W-1:0];
      compared_avg        = avg[AVG_W-1:0];
      sample_sum          = '0;
      samples_taken       = '0;
      res.average_updated = 1'b1;
    end
    if (tick.run_active) begin
      if (!armed) begin
        if (blank_ticks != BLANK_MAX) begin
          blank_ticks = blank_ticks + BLANK_W'(1);
        end
        if (blank_ticks >= blank_reg) begin
          armed = 1'b1;
        end
      end
    end else begin
      armed        = 1'b0;
      blank_ticks  = '0;
      compared_avg = '0;
    end
    res.crush_detected  = armed && (compared_avg > limit_reg);
    res.average_current = reported_avg;
    return res;
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    mccd_out_t due;
    if (rst) begin
      limit_reg      = LIMIT_RESET;
      interval_reg   = INTERVAL_RESET;
      count_reg      = COUNT_RESET;
      blank_reg      = BLANK_RESET;
      interval_ticks = '0;
      sample_sum     = '0;
      samples_taken  = '0;
      reported_avg   = '0;
      compared_avg   = '0;
      blank_ticks    = '0;
      armed          = 1'b0;
      tick_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CURRENT_LIMIT:   limit_reg    = cfg_data[LIMIT_W-1:0];
          REG_SAMPLE_INTERVAL: interval_reg = cfg_data[INTERVAL_W-1:0];
          REG_SAMPLE_COUNT:    count_reg    = cfg_data[COUNT_W-1:0];
          REG_BLANK_TIME:      blank_reg    = cfg_data[BLANK_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        tick_results.push_back(predict_tick(in_data));
      end
      if (out_valid && out_ready) begin
        if (tick_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with no tick waiting: crush %0b avg %0d upd %0b", $time,
                     out_data.crush_detected, out_data.average_current,
                     out_data.average_updated);
          end
        end else begin
          due = tick_results.pop_front();
          check_field("crush_detected", 32'(due.crush_detected),
                      32'(out_data.crush_detected));
          check_field("average_current", 32'(due.average_current),
                      32'(out_data.average_current));
          check_field("average_updated", 32'(due.average_updated),
                      32'(out_data.average_updated));
        end
      end
    end
    results_due = tick_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the motor current crush detector: clock, reset, register writes
// and tick stimulus with random idling; the verdict comes from mccd_tick_checker.
// Depends on mccd_pkg, motor_current_crush_detector_top and mccd_tick_checker.
module tb_top;
  import mccd_pkg::*;

  bit                     clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  mccd_in_t               in_data;
  logic                   out_valid;
  logic                   out_ready;
  mccd_out_t              out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     mismatches;
  int                     results_due;
  bit                     steady;

  motor_current_crush_detector_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mccd_tick_checker tick_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= steady || ($urandom_range(0, 99) >= 7);
    end
  end

  task automatic send_tick(logic run, logic [SAMPLE_BITS-1:0] sample);
    if (!steady && $urandom_range(0, 99) < 7) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= mccd_in_t'{run, sample};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [LIMIT_W-1:0]    limit;
    logic [INTERVAL_W-1:0] interval;
    logic [COUNT_W-1:0]    count;
    logic [BLANK_W-1:0]    blank;
    int                    n_ticks;
    int                    run_left;
    int                    level;
    int unsigned           roll;
    logic                  running;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    steady    = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 8; i++) begin
      send_tick(i[0], i[1] ? AVG_MAX : '0);
    end
    drain();
    write_reg(REG_CURRENT_LIMIT, '0);
    write_reg(REG_SAMPLE_INTERVAL, '0);
    write_reg(REG_SAMPLE_COUNT, '0);
    write_reg(REG_BLANK_TIME, '0);
    send_tick(1'b1, AVG_MAX);
    send_tick(1'b1, '0);
    send_tick(1'b1, SAMPLE_BITS'(1));
    send_tick(1'b0, AVG_MAX);
    send_tick(1'b1, SAMPLE_BITS'(512));
    drain();
    write_reg(REG_CURRENT_LIMIT, CFG_DATA_W'(AVG_MAX));
    send_tick(1'b1, AVG_MAX);
    drain();
    write_reg(REG_CURRENT_LIMIT, CFG_DATA_W'(341));
    write_reg(REG_SAMPLE_INTERVAL, CFG_DATA_W'(1));
    write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(8));
    write_reg(REG_BLANK_TIME, CFG_DATA_W'(3));
    send_tick(1'b1, SAMPLE_BITS'(10'h2AA));
    send_tick(1'b1, SAMPLE_BITS'(10'h155));
    send_tick(1'b1, SAMPLE_BITS'(700));
    send_tick(1'b1, SAMPLE_BITS'(10'h155));
    send_tick(1'b1, SAMPLE_BITS'(10'h2AA));
    drain();
    write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(2));
    send_tick(1'b1, SAMPLE_BITS'(900));

    running  = 1'b0;
    run_left = 0;
    for (int p = 0; p < 12; p++) begin
      drain();
      limit    = (p == 0) ? '0 : (p == 1) ? AVG_MAX : LIMIT_W'($urandom_range(50, 900));
      interval = (p == 3) ? INTERVAL_W'(1) : (p == 5) ? INTERVAL_W'(255) :
                 (p == 7) ? '0 : INTERVAL_W'($urandom_range(1, 3));
      count    = (p == 3) ? COUNT_W'(255) : (p == 5) ? COUNT_W'(1) :
                 (p == 8) ? '0 : COUNT_W'($urandom_range(1, 8));
      blank    = (p == 2) ? '0 : (p == 9) ? BLANK_MAX : BLANK_W'($urandom_range(1, 40));
      write_reg(REG_CURRENT_LIMIT, {6'($urandom), limit});
      write_reg(REG_SAMPLE_INTERVAL, {8'($urandom), interval});
      write_reg(REG_SAMPLE_COUNT, {8'($urandom), count});
      write_reg(REG_BLANK_TIME, blank);
      write_reg(CFG_INDEX_W'($urandom_range(REG_BLANK_TIME + 1, 255)),
                CFG_DATA_W'($urandom));
      steady  = (p == 6);
      n_ticks = (p == 3) ? 280 : (p == 5) ? 300 : 90;
      for (int t = 0; t < n_ticks; t++) begin
        if (run_left == 0) begin
          running  = ($urandom_range(0, 99) < 80);
          run_left = running ? $urandom_range(10, 80) : $urandom_range(1, 5);
        end
        run_left--;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          level = int'(limit) + int'($urandom_range(0, 100)) - 50;
          if (level < 0) level = 0;
          if (level > int'(AVG_MAX)) level = int'(AVG_MAX);
        end else if (roll < 85) begin
          level = $urandom_range(0, 1) ? int'(AVG_MAX) : 0;
        end else begin
          level = $urandom_range(0, 1023);
        end
        send_tick(running ^ ($urandom_range(0, 99) < 3), SAMPLE_BITS'(level));
      end
    end

    steady = 1'b0;
    drain();
    repeat (25) @(posedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
